@@ design/pdg_pkg.sv @@
// Shared types and constants for the pixel difference gate.
`timescale 1ns / 1ps
package pdg_pkg;

    localparam int CHAN_W     = 8;
    localparam int THR_W      = 17;
    localparam int ROW_W      = 15;
    localparam int CNT_W      = 29;
    localparam int PROD_W     = THR_W + CNT_W;
    localparam int FRAC_W     = 16;
    localparam int NUM_CHAN   = 4;
    localparam int PIX_W      = 2 * NUM_CHAN * CHAN_W;
    localparam int OUT_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [ROW_W-1:0] MAX_DIM = ROW_W'(16384);
    localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CHAN_W-1:0] TOL_RESET  = CHAN_W'(2);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(655);
    localparam logic [ROW_W-1:0]  FOLD_RESET = ROW_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_FOLD      = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    // One classified pixel, passed from front to back.
    typedef struct packed {
        logic counted;   // row is above the fold
        logic differs;   // some channel out of tolerance
        logic last;      // image end
    } t_pix_rec;

endpackage

@@ design/pixel_diff_gate.sv @@
// Top level of the pixel difference gate: config registers and stream wiring.
`timescale 1ns / 1ps
// Compares aligned RGBA reference/candidate pixel pairs at one pixel beat per
// clock. A pixel counts as different when any channel's absolute difference
// exceeds channel_tolerance; only rows below min(fold_height, 16384) are
// counted. The beat flagged with tlast (image end) produces one result beat
// holding the differing count, the compared count and a pass flag
// (diff * 65536 <= threshold_q16 * total, or nothing compared), and clears
// the counters. The front classifies each beat in the cycle it arrives and
// feeds a four-entry queue; the back counts one entry per cycle, holding an
// image-end entry while the capture stage is full and cannot advance, and
// runs the pass check through three registered stages (capture, multiply,
// compare). Output stalls back up through the queue before the input tready
// drops. Configuration writes are always accepted and must be made while no
// image is in flight.
module pixel_diff_gate
    import pdg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ref_red, ref_green, ref_blue, ref_alpha, cand_red, cand_green, cand_blue, cand_alpha
    input  logic [PIX_W-1:0]      s_axis_tdata,
    // row_end
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // differing count [28:0], compared count [57:29], passed [58], zero pad
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CHAN_W-1:0] r_tolerance;
    logic [THR_W-1:0]  r_threshold;
    logic [ROW_W-1:0]  r_fold;

    logic       q_full, q_push, q_valid, q_pop;
    t_pix_rec   front_rec, q_rec;
    logic [CNT_W-1:0] res_diff, res_total;
    logic       res_passed;
    t_cfg_idx   cfg_idx;

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
            r_threshold <= THR_RESET;
            r_fold      <= FOLD_RESET;
        end else if (i_cfg_valid) begin
            case (cfg_idx)
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[CHAN_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_FOLD:      r_fold      <= i_cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    pdg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixels    (s_axis_tdata),
        .i_row_end   (s_axis_tuser),
        .i_image_end (s_axis_tlast),
        .i_tolerance (r_tolerance),
        .i_fold      (r_fold),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (front_rec)
    );

    pdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    pdg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_rec       (q_rec),
        .o_pop       (q_pop),
        .i_threshold (r_threshold),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_diff      (res_diff),
        .o_total     (res_total),
        .o_passed    (res_passed)
    );

    assign m_axis_tdata = {{(OUT_W - 2*CNT_W - 1){1'b0}}, res_passed, res_total, res_diff};

endmodule

@@ design/pdg_front.sv @@
// Front end: accepts pixel beats, tracks rows and classifies each pixel.
`timescale 1ns / 1ps
module pdg_front
    import pdg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_pixels,
    input  logic                  i_row_end,
    input  logic                  i_image_end,
    input  logic [CHAN_W-1:0]     i_tolerance,
    input  logic [ROW_W-1:0]      i_fold,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_pix_rec              o_rec
);

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [ROW_W-1:0] fold_eff;
    logic [NUM_CHAN-1:0] chan_over;
    logic [CHAN_W-1:0] ref_c [NUM_CHAN];
    logic [CHAN_W-1:0] cand_c [NUM_CHAN];
    logic [CHAN_W-1:0] adiff [NUM_CHAN];

    assign o_ready  = !i_q_full;
    assign o_push   = i_valid && !i_q_full;
    assign fold_eff = (i_fold > MAX_DIM) ? MAX_DIM : i_fold;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            ref_c[c]  = i_pixels[c*CHAN_W +: CHAN_W];
            cand_c[c] = i_pixels[(c+NUM_CHAN)*CHAN_W +: CHAN_W];
            adiff[c]  = (ref_c[c] > cand_c[c]) ? (ref_c[c] - cand_c[c])
                                               : (cand_c[c] - ref_c[c]);
            chan_over[c] = adiff[c] > i_tolerance;
        end
    end

    always_comb begin
        o_rec.counted = r_row < fold_eff;
        o_rec.differs = |chan_over;
        o_rec.last    = i_image_end;
    end

    always_comb begin
        n_row = r_row;
        if (o_push) begin
            if (i_image_end) begin
                n_row = '0;
            end else if (i_row_end && r_row != ROW_MAX) begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

@@ design/pdg_queue.sv @@
// Short queue of classified pixels between front and back.
`timescale 1ns / 1ps
module pdg_queue
    import pdg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_pix_rec i_rec,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_pix_rec o_rec
);

    t_pix_rec               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   do_pop;

    assign o_full  = r_count == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                   : r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                   : r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/pdg_back.sv @@
// Back end: pixel counters and the pass check pipeline for one image result.
`timescale 1ns / 1ps
module pdg_back
    import pdg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_pix_rec         i_rec,
    output logic             o_pop,
    input  logic [THR_W-1:0] i_threshold,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CNT_W-1:0] o_diff,
    output logic [CNT_W-1:0] o_total,
    output logic             o_passed
);

    logic [CNT_W-1:0]  r_diff, r_total;
    logic [CNT_W-1:0]  n_diff, n_total;

    logic              r_s1_valid;
    logic [CNT_W-1:0]  r_s1_diff, r_s1_total;
    logic              r_s2_valid;
    logic [CNT_W-1:0]  r_s2_diff, r_s2_total;
    logic [PROD_W-1:0] r_s2_prod;
    logic              r_o_valid;
    logic [CNT_W-1:0]  r_o_diff, r_o_total;
    logic              r_o_passed;

    logic out_free, s2_free, s1_free, s2_adv, s1_adv, take, take_last;
    logic [PROD_W-1:0] lhs;

    assign out_free  = !r_o_valid || i_ready;
    assign s2_adv    = r_s2_valid && out_free;
    assign s2_free   = !r_s2_valid || out_free;
    assign s1_adv    = r_s1_valid && s2_free;
    assign s1_free   = !r_s1_valid || s2_free;
    assign o_pop     = i_valid && (!i_rec.last || s1_free);
    assign take      = o_pop;
    assign take_last = take && i_rec.last;

    // counts after this pixel, saturating
    always_comb begin
        n_diff  = r_diff;
        n_total = r_total;
        if (i_rec.counted) begin
            if (r_total != CNT_MAX) begin
                n_total = r_total + CNT_W'(1);
            end
            if (i_rec.differs && r_diff != CNT_MAX) begin
                n_diff = r_diff + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff  <= '0;
            r_total <= '0;
        end else if (take) begin
            r_diff  <= i_rec.last ? '0 : n_diff;
            r_total <= i_rec.last ? '0 : n_total;
        end
    end

    // diff * 2^16 against threshold * total
    assign lhs = {{(PROD_W-CNT_W-FRAC_W){1'b0}}, r_s2_diff, {FRAC_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_s1_diff  <= n_diff;
            r_s1_total <= n_total;
        end
        if (s1_adv) begin
            r_s2_diff  <= r_s1_diff;
            r_s2_total <= r_s1_total;
            r_s2_prod  <= PROD_W'(i_threshold) * PROD_W'(r_s1_total);
        end
        if (s2_adv) begin
            r_o_diff   <= r_s2_diff;
            r_o_total  <= r_s2_total;
            r_o_passed <= (r_s2_total == '0) || (lhs <= r_s2_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (take_last) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_diff   = r_o_diff;
    assign o_total  = r_o_total;
    assign o_passed = r_o_passed;

    a_last_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> r_s1_valid)
        else $error("image end beat did not load the result stage");

    a_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_last |=> (r_diff == '0 && r_total == '0))
        else $error("counters not cleared after image end");

    a_diff_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff <= r_total)
        else $error("differing count exceeds compared count");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_free) |=> (r_s2_valid && $stable(r_s2_prod)))
        else $error("product stage lost data under output stall");

endmodule
